[sv/tcce_pkg.sv]
package tcce_pkg;

  // Field widths fixed by the stream formats.
  localparam int COL_W     = 7;
  localparam int ROW_W     = 5;
  localparam int IDX_W     = 11;
  localparam int LOC_OUT_W = 11;
  localparam int CHAR_W    = 8;
  localparam int COLOR_W   = 8;
  localparam int CELL_W    = 16;
  localparam int CFG_IDX_W = 3;

  // Item commands.
  localparam logic CMD_PUT  = 1'b0;
  localparam logic CMD_READ = 1'b1;

  // Fixed character codes and the cell written by the clearing pass.
  localparam logic [CHAR_W-1:0] CODE_NEWLINE   = 8'd10;
  localparam logic [CHAR_W-1:0] CODE_BACKSPACE = 8'd8;
  localparam logic [CHAR_W-1:0] CODE_SPACE     = 8'd32;
  localparam logic [CELL_W-1:0] RESET_CELL     = 16'h0F20;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_TEXT_COLOR = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_KEY_UP     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_KEY_DOWN   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_KEY_LEFT   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_KEY_RIGHT  = 3'd4;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;   // latch the input beat
    logic exec;      // carry out the latched item
    logic clear_wr;  // clearing pass: write the reset cell at the counter
    logic copy_rd;   // scroll: read the cell one row below the counter
    logic fill_wr;   // scroll: write a blank at the counter
    logic load_out;  // load the result register
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic cnt_last;       // counter on the last cell of the store
    logic cnt_copy_last;  // counter on the last cell that the copy writes
    logic scroll;         // the item being carried out needs a scroll
    logic out_busy;       // result register holds a beat not yet taken
  } status_t;

endpackage

[sv/tcce_ctrl.sv]
module tcce_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  tcce_pkg::status_t status,
  output tcce_pkg::cmd_t    cmd
);
  import tcce_pkg::*;

  typedef enum logic [6:0] {
    ST_CLEAR = 7'b0000001,
    ST_IDLE  = 7'b0000010,
    ST_EXEC  = 7'b0000100,
    ST_COPY  = 7'b0001000,
    ST_DRAIN = 7'b0010000,
    ST_FILL  = 7'b0100000,
    ST_RESP  = 7'b1000000
  } state_t;

  state_t state;
  state_t state_next;

  // State register; reset starts the clearing pass over the store.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // Next state and commands.
  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    case (state)
      ST_CLEAR: begin
        cmd.clear_wr = 1'b1;
        if (status.cnt_last) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_next  = ST_EXEC;
        end
      end
      ST_EXEC: begin
        cmd.exec   = 1'b1;
        state_next = status.scroll ? ST_COPY : ST_RESP;
      end
      ST_COPY: begin
        cmd.copy_rd = 1'b1;
        if (status.cnt_copy_last) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        // The last copied cell is written in this cycle.
        state_next = ST_FILL;
      end
      ST_FILL: begin
        cmd.fill_wr = 1'b1;
        if (status.cnt_last) begin
          state_next = ST_RESP;
        end
      end
      ST_RESP: begin
        if (!status.out_busy) begin
          cmd.load_out = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_CLEAR;
      end
    endcase
  end

endmodule

[sv/tcce_dp.sv]
module tcce_dp #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  tcce_pkg::cmd_t                       cmd,
  output tcce_pkg::status_t                    status,
  input  logic                                 item_command,
  input  logic [tcce_pkg::CHAR_W-1:0]          item_char,
  input  logic [tcce_pkg::IDX_W-1:0]           item_index,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [tcce_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [7:0]                           cfg_data,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic [tcce_pkg::COL_W-1:0]           out_col,
  output logic [tcce_pkg::ROW_W-1:0]           out_row,
  output logic [tcce_pkg::LOC_OUT_W-1:0]       out_loc,
  output logic [tcce_pkg::CELL_W-1:0]          out_cell
);
  import tcce_pkg::*;

  localparam int CELLS = COLUMNS * ROWS;
  localparam int AW    = $clog2(CELLS);
  localparam int RW    = (AW + 1 > IDX_W) ? AW + 1 : IDX_W;
  localparam int LOC_W = (AW > LOC_OUT_W) ? AW : LOC_OUT_W;

  // Configuration registers.
  logic [COLOR_W-1:0] text_color;
  logic [CHAR_W-1:0]  key_up;
  logic [CHAR_W-1:0]  key_down;
  logic [CHAR_W-1:0]  key_left;
  logic [CHAR_W-1:0]  key_right;

  // Latched item.
  logic              item_cmd;
  logic [CHAR_W-1:0] item_code;
  logic [AW-1:0]     item_addr;
  logic              item_rd_ok;

  // Cursor, sweep counter and copy pipeline.
  logic [COL_W-1:0] col;
  logic [COL_W-1:0] col_next;
  logic [ROW_W-1:0] row;
  logic [ROW_W-1:0] row_next;
  logic [AW-1:0]    cnt;
  logic [AW-1:0]    cnt_next;
  logic             copy_valid;
  logic [AW-1:0]    copy_addr;
  logic             out_valid_next;

  // Cell store ports.
  logic [CELL_W-1:0] mem [CELLS];
  logic              rd_en;
  logic [AW-1:0]     rd_addr;
  logic [CELL_W-1:0] rd_data;
  logic              wr_en;
  logic [AW-1:0]     wr_addr;
  logic [CELL_W-1:0] wr_data;

  logic [AW-1:0]    loc;
  logic [LOC_W-1:0] loc_ext;
  logic             scroll;
  logic             at_last_col;
  logic             at_last_row;

  assign cfg_ready = 1'b1;

  // Configuration writes; unknown indexes are dropped.
  always_ff @(posedge clk) begin
    if (rst) begin
      text_color <= 8'd15;
      key_up     <= 8'd128;
      key_down   <= 8'd129;
      key_left   <= 8'd130;
      key_right  <= 8'd131;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_TEXT_COLOR: text_color <= cfg_data;
        CFG_KEY_UP:     key_up     <= cfg_data;
        CFG_KEY_DOWN:   key_down   <= cfg_data;
        CFG_KEY_LEFT:   key_left   <= cfg_data;
        CFG_KEY_RIGHT:  key_right  <= cfg_data;
        default: ;
      endcase
    end
  end

  // Input beat latch, with the range check of the read index.
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      item_cmd   <= item_command;
      item_code  <= item_char;
      item_addr  <= AW'(item_index);
      item_rd_ok <= RW'(item_index) < RW'(CELLS);
    end
  end

  // Linear cursor location.
  assign loc         = AW'(col) + AW'(row) * AW'(COLUMNS);
  assign loc_ext     = LOC_W'(loc);
  assign at_last_col = (col == COL_W'(COLUMNS - 1));
  assign at_last_row = (row == ROW_W'(ROWS - 1));

  // Store writes and cursor update; the put item is decoded here.
  always_comb begin
    wr_en    = 1'b0;
    wr_addr  = '0;
    wr_data  = '0;
    col_next = col;
    row_next = row;
    scroll   = 1'b0;
    if (cmd.clear_wr) begin
      wr_en   = 1'b1;
      wr_addr = cnt;
      wr_data = RESET_CELL;
    end else if (cmd.fill_wr) begin
      wr_en   = 1'b1;
      wr_addr = cnt;
      wr_data = {text_color, CODE_SPACE};
    end else if (copy_valid) begin
      wr_en   = 1'b1;
      wr_addr = copy_addr;
      wr_data = rd_data;
    end else if (cmd.exec && item_cmd == CMD_PUT) begin
      if (item_code == CODE_NEWLINE) begin
        col_next = '0;
        if (at_last_row) begin
          scroll = 1'b1;
        end else begin
          row_next = row + ROW_W'(1);
        end
      end else if (item_code == CODE_BACKSPACE) begin
        if (!(row == '0 && col == '0)) begin
          if (col != '0) begin
            col_next = col - COL_W'(1);
          end else begin
            col_next = COL_W'(COLUMNS - 1);
            row_next = row - ROW_W'(1);
          end
          // Stepping back is always one cell back in linear order.
          wr_en   = 1'b1;
          wr_addr = loc - AW'(1);
          wr_data = {text_color, CODE_SPACE};
        end
      end else if (item_code == key_up) begin
        if (row != '0) begin
          row_next = row - ROW_W'(1);
        end
      end else if (item_code == key_down) begin
        if (!at_last_row) begin
          row_next = row + ROW_W'(1);
        end
      end else if (item_code == key_left) begin
        if (col != '0) begin
          col_next = col - COL_W'(1);
        end
      end else if (item_code == key_right) begin
        if (!at_last_col) begin
          col_next = col + COL_W'(1);
        end
      end else begin
        wr_en   = 1'b1;
        wr_addr = loc;
        wr_data = {text_color, item_code};
        if (at_last_col) begin
          col_next = '0;
          if (at_last_row) begin
            scroll = 1'b1;
          end else begin
            row_next = row + ROW_W'(1);
          end
        end else begin
          col_next = col + COL_W'(1);
        end
      end
    end
  end

  // Store reads: the scroll copy or the cell of a read item.
  assign rd_en   = cmd.copy_rd || (cmd.exec && item_cmd == CMD_READ && item_rd_ok);
  assign rd_addr = cmd.copy_rd ? cnt + AW'(COLUMNS) : item_addr;

  // Cell store with registered read data.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  // Sweep counter: restarts at each item, wraps after the last cell.
  always_comb begin
    cnt_next = cnt;
    if (cmd.exec) begin
      cnt_next = '0;
    end else if (cmd.clear_wr || cmd.fill_wr) begin
      cnt_next = status.cnt_last ? '0 : cnt + AW'(1);
    end else if (cmd.copy_rd) begin
      cnt_next = cnt + AW'(1);
    end
  end

  // Result register handshake.
  assign out_valid_next = cmd.load_out ? 1'b1 : (out_ready ? 1'b0 : out_valid);

  // Control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      col        <= '0;
      row        <= '0;
      cnt        <= '0;
      copy_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      col        <= col_next;
      row        <= row_next;
      cnt        <= cnt_next;
      copy_valid <= cmd.copy_rd;
      out_valid  <= out_valid_next;
    end
  end

  // Copy destination: the counter, registered so that the write lands in the cycle after the read.
  always_ff @(posedge clk) begin
    if (cmd.copy_rd) begin
      copy_addr <= cnt;
    end
  end

  // Result payload, taken from the cursor after the item.
  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_col  <= col;
      out_row  <= row;
      out_loc  <= loc_ext[LOC_OUT_W-1:0];
      out_cell <= (item_cmd == CMD_READ && item_rd_ok) ? rd_data : '0;
    end
  end

  // Status to the controller.
  assign status.cnt_last      = (cnt == AW'(CELLS - 1));
  assign status.cnt_copy_last = (cnt == AW'(CELLS - COLUMNS - 1));
  assign status.scroll        = scroll;
  assign status.out_busy      = out_valid && !out_ready;

  // The cursor never leaves the screen.
  assert property (@(posedge clk) disable iff (rst)
    (col < COL_W'(COLUMNS)) && (row < ROW_W'(ROWS)))
    else $error("cursor outside the screen");

  // The copy never writes into the bottom row.
  assert property (@(posedge clk) disable iff (rst)
    copy_valid |-> (copy_addr < AW'(CELLS - COLUMNS)))
    else $error("scroll copy wrote into the bottom row");

  // The trailing copy write never meets another writer.
  assert property (@(posedge clk) disable iff (rst)
    copy_valid |-> !(cmd.exec || cmd.fill_wr || cmd.clear_wr))
    else $error("copy write collides with another store write");

  // A result is loaded only when the previous one has been taken.
  assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |-> !(out_valid && !out_ready))
    else $error("result register overwritten before it was taken");

endmodule

[sv/text_console_char_engine.sv]
// Text console engine over a store of COLUMNS*ROWS 16-bit cells (colour byte over
// character byte) with a cursor. An input beat with tuser 0 puts the character in
// tdata: newline, backspace and the four configured arrow codes move the cursor,
// any other code is written at the cursor in text_color. A beat with tuser 1 reads
// the cell at read_index (0 when out of range). Each input beat gives one output
// beat with the cursor after the item. One item is handled at a time: an item is
// accepted, executed and its result loaded, and a new beat is accepted in the
// cycle after the result is loaded. An item that moves past the last row also
// scrolls the store through its single read and single write port, one cell per
// cycle: COLUMNS*ROWS - COLUMNS copies, a drain step that writes the last copy,
// and COLUMNS blank fills. After reset a clearing pass writes every cell, during
// which no input beat is taken; configuration writes are taken at any time.
module text_console_char_engine #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  input  logic [23:0]                         s_axis_tdata,  // char_code, read_index
  input  logic                                s_axis_tuser,  // command
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // cursor_col, cursor_row, cursor_loc, cell_data
  output logic [39:0]                         m_axis_tdata,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [tcce_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [7:0]                          cfg_data
);
  import tcce_pkg::*;

  cmd_t                 cmd;
  status_t              status;
  logic [COL_W-1:0]     out_col;
  logic [ROW_W-1:0]     out_row;
  logic [LOC_OUT_W-1:0] out_loc;
  logic [CELL_W-1:0]    out_cell;

  tcce_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .status   (status),
    .cmd      (cmd)
  );

  tcce_dp #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .status       (status),
    .item_command (s_axis_tuser),
    .item_char    (s_axis_tdata[7:0]),
    .item_index   (s_axis_tdata[18:8]),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .out_valid    (m_axis_tvalid),
    .out_ready    (m_axis_tready),
    .out_col      (out_col),
    .out_row      (out_row),
    .out_loc      (out_loc),
    .out_cell     (out_cell)
  );

  assign m_axis_tdata = {1'b0, out_cell, out_loc, out_row, out_col};

endmodule

[bench/text_console_char_engine_tb.sv]
`timescale 1ns / 100ps

module text_console_char_engine_tb;
  import tcce_pkg::*;

  localparam int COLS           = 80;
  localparam int ROWS           = 25;
  localparam int CELLS          = COLS * ROWS;
  // The longest quiet stretch is a clearing pass or a scroll.
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int SETTLE_CYCLES  = 10;

  // One result beat, laid out as on m_axis_tdata, fields listed from the top bit down.
  typedef struct packed {
    logic [CELL_W-1:0]    data;
    logic [LOC_OUT_W-1:0] loc;
    logic [ROW_W-1:0]     row;
    logic [COL_W-1:0]     col;
  } cursor_report_t;

  logic                 clk;
  logic                 rst           = 1'b1;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [23:0]          s_axis_tdata  = '0;  // char_code, read_index
  logic                 s_axis_tuser  = 1'b0;  // command
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [39:0]          m_axis_tdata;  // cursor_col, cursor_row, cursor_loc, cell_data
  logic                 cfg_valid     = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index     = '0;
  logic [7:0]           cfg_data      = '0;

  // Predicted console state and register copies.
  logic [CELL_W-1:0]  screen [0:CELLS-1];
  int                 pos_col;
  int                 pos_row;
  logic [COLOR_W-1:0] attr;
  logic [CHAR_W-1:0]  up_key, down_key, left_key, right_key;

  cursor_report_t pending_reports [$];

  int fail_count     = 0;
  int items_sent     = 0;
  int put_count      = 0;
  int read_count     = 0;
  int oob_read_count = 0;
  int scroll_count   = 0;
  int reg_writes     = 0;
  int quiet_cycles   = 0;
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;

  text_console_char_engine #(
    .COLUMNS(COLS),
    .ROWS   (ROWS)
  ) uut (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Move the cursor down a row, scrolling the screen when already on the bottom row.
  function automatic void line_feed();
    if (pos_row + 1 >= ROWS) begin
      for (int i = 0; i < CELLS - COLS; i++) screen[i] = screen[i + COLS];
      for (int i = CELLS - COLS; i < CELLS; i++) screen[i] = {attr, CODE_SPACE};
      scroll_count++;
    end else begin
      pos_row++;
    end
  endfunction

  // Apply one accepted item to the predicted state and return the expected beat.
  function automatic cursor_report_t predict_report(input logic cmd,
                                                    input logic [CHAR_W-1:0] ch,
                                                    input logic [IDX_W-1:0] idx);
    cursor_report_t r;
    r = '0;
    if (cmd == CMD_PUT) begin
      // Control codes are matched in a fixed order; the first match wins.
      if (ch == CODE_NEWLINE) begin
        pos_col = 0;
        line_feed();
      end else if (ch == CODE_BACKSPACE) begin
        if (pos_row != 0 || pos_col != 0) begin
          if (pos_col != 0) begin
            pos_col--;
          end else begin
            pos_col = COLS - 1;
            pos_row--;
          end
          screen[pos_col + pos_row * COLS] = {attr, CODE_SPACE};
        end
      end else if (ch == up_key) begin
        if (pos_row != 0) pos_row--;
      end else if (ch == down_key) begin
        if (pos_row + 1 < ROWS) pos_row++;
      end else if (ch == left_key) begin
        if (pos_col != 0) pos_col--;
      end else if (ch == right_key) begin
        if (pos_col + 1 < COLS) pos_col++;
      end else begin
        screen[pos_col + pos_row * COLS] = {attr, ch};
        pos_col++;
        if (pos_col >= COLS) begin
          pos_col = 0;
          line_feed();
        end
      end
    end else if (idx < CELLS) begin
      r.data = screen[idx];
    end
    r.col = COL_W'(pos_col);
    r.row = ROW_W'(pos_row);
    r.loc = LOC_OUT_W'(pos_col + pos_row * COLS);
    return r;
  endfunction

  // A random code that the current settings print rather than act on.
  function automatic logic [CHAR_W-1:0] pick_text_char();
    logic [CHAR_W-1:0] c;
    do begin
      c = CHAR_W'($urandom_range(255));
    end while (c == CODE_NEWLINE || c == CODE_BACKSPACE || c == up_key ||
               c == down_key || c == left_key || c == right_key);
    return c;
  endfunction

  // Offer one input beat, with random idle cycles ahead of it, and predict its result.
  // tvalid stays high after acceptance until the next beat or a pause changes it.
  task automatic send_item(input logic cmd, input logic [CHAR_W-1:0] ch,
                           input logic [IDX_W-1:0] idx);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {5'b0, idx, ch};
    s_axis_tuser  <= cmd;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    pending_reports.push_back(predict_report(cmd, ch, idx));
    items_sent++;
    if (cmd == CMD_READ) begin
      read_count++;
      if (idx >= CELLS) oob_read_count++;
    end else begin
      put_count++;
    end
  endtask

  task automatic type_code(input logic [CHAR_W-1:0] ch);
    send_item(CMD_PUT, ch, IDX_W'($urandom_range(2047)));
  endtask

  task automatic read_cell(input logic [IDX_W-1:0] idx);
    send_item(CMD_READ, CHAR_W'($urandom_range(255)), idx);
  endtask

  // Stop offering beats and wait for every outstanding result.
  task automatic drain_reports();
    @(negedge clk);
    s_axis_tvalid <= 1'b0;
    while (pending_reports.size() != 0) @(posedge clk);
  endtask

  // Write one register; only called while the block is idle.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] val);
    @(negedge clk);
    s_axis_tvalid <= 1'b0;
    cfg_valid     <= 1'b1;
    cfg_index     <= idx;
    cfg_data      <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      CFG_TEXT_COLOR: attr      = val;
      CFG_KEY_UP:     up_key    = val;
      CFG_KEY_DOWN:   down_key  = val;
      CFG_KEY_LEFT:   left_key  = val;
      CFG_KEY_RIGHT:  right_key = val;
      default: ;
    endcase
    reg_writes++;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic write_all_regs(input logic [7:0] color, input logic [7:0] up,
                                input logic [7:0] down, input logic [7:0] left,
                                input logic [7:0] right);
    drain_reports();
    write_reg(CFG_TEXT_COLOR, color);
    write_reg(CFG_KEY_UP, up);
    write_reg(CFG_KEY_DOWN, down);
    write_reg(CFG_KEY_LEFT, left);
    write_reg(CFG_KEY_RIGHT, right);
  endtask

  // Random traffic built from bursts: text lines, arrow runs, backspace runs,
  // newline runs, cell reads and unconstrained noise.
  task automatic random_traffic(input int n_items, input int send_pct, input int recv_pct);
    int                 start;
    int                 kind;
    int                 len;
    int                 spot;
    logic [CHAR_W-1:0]  key;
    logic [IDX_W-1:0]   at;
    start = items_sent;
    while (items_sent - start < n_items) begin
      // Some bursts run with no idling at all, so back-to-back beats occur in every phase.
      if ($urandom_range(99) < 20) begin
        send_idle_pct  = 0;
        recv_stall_pct = 0;
      end else begin
        send_idle_pct  = send_pct;
        recv_stall_pct = recv_pct;
      end
      // Now and then the sender holds off until the block has answered everything.
      if ($urandom_range(99) < 4) drain_reports();
      kind = $urandom_range(99);
      if (kind < 35) begin
        // A line of text, often longer than a row, usually ended by a newline.
        len = $urandom_range(1, 120);
        repeat (len) type_code(pick_text_char());
        if ($urandom_range(9) < 7) type_code(CODE_NEWLINE);
      end else if (kind < 50) begin
        case ($urandom_range(3))
          0:       key = up_key;
          1:       key = down_key;
          2:       key = left_key;
          default: key = right_key;
        endcase
        len = ($urandom_range(3) == 0) ? $urandom_range(20, 90) : $urandom_range(1, 12);
        repeat (len) type_code(key);
      end else if (kind < 58) begin
        len = ($urandom_range(3) == 0) ? $urandom_range(20, 90) : $urandom_range(1, 12);
        repeat (len) type_code(CODE_BACKSPACE);
      end else if (kind < 68) begin
        repeat ($urandom_range(1, 12)) type_code(CODE_NEWLINE);
      end else if (kind < 85) begin
        repeat ($urandom_range(1, 8)) begin
          case ($urandom_range(3))
            0: begin
              // Around the cursor, where the last writes landed.
              spot = pos_col + pos_row * COLS + $urandom_range(4);
              at   = IDX_W'((spot >= 2) ? spot - 2 : 0);
            end
            1: at = IDX_W'($urandom_range(2047));
            2: begin
              case ($urandom_range(3))
                0:       at = '0;
                1:       at = IDX_W'(CELLS - 1);
                2:       at = IDX_W'(CELLS);
                default: at = 11'h7FF;
              endcase
            end
            default: at = IDX_W'($urandom_range(CELLS - COLS, CELLS - 1));
          endcase
          read_cell(at);
        end
      end else begin
        repeat ($urandom_range(1, 10))
          send_item(1'($urandom_range(1)), CHAR_W'($urandom_range(255)),
                    IDX_W'($urandom_range(2047)));
      end
    end
    drain_reports();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
  endtask

  // Reset values, store corners, every control code and the top, left and right edges.
  task automatic test_directed_codes();
    read_cell('0);
    read_cell(IDX_W'(CELLS - 1));
    read_cell(IDX_W'(CELLS));
    read_cell(11'h7FF);
    type_code(CODE_BACKSPACE);   // nothing happens at the origin
    type_code(up_key);
    type_code(left_key);
    type_code(8'h00);
    type_code(8'hFF);
    type_code("A");
    type_code(right_key);
    type_code(down_key);
    type_code(left_key);
    type_code(up_key);
    type_code(CODE_BACKSPACE);
    type_code(CODE_NEWLINE);
    type_code(CODE_BACKSPACE);   // wraps back to the last column of the row above
    type_code(right_key);        // already on the right edge
    type_code(pick_text_char()); // last column, so the cursor wraps
    read_cell(IDX_W'(COLS - 1));
    read_cell(11'd0);
    read_cell(11'd1);
    read_cell(11'd2);
    drain_reports();
  endtask

  // Walk to the bottom edge, scroll by newline and by printing in the last cell,
  // then read back the copied row and the blank fill.
  task automatic test_scroll_and_edges();
    drain_reports();
    write_reg(CFG_TEXT_COLOR, 8'($urandom_range(255)));
    repeat ($urandom_range(ROWS + 1, ROWS + 7)) type_code(down_key);
    repeat ($urandom_range(1, 6)) type_code(pick_text_char());
    type_code(CODE_NEWLINE);
    repeat ($urandom_range(COLS + 5, COLS + 10)) type_code(right_key);
    type_code(pick_text_char());
    repeat (6) read_cell(IDX_W'($urandom_range(CELLS - 2 * COLS, CELLS - 1)));
    drain_reports();
  endtask

  // Extreme key codes and a black-on-black attribute, no idling.
  task automatic test_extreme_key_codes();
    write_all_regs(8'h00, 8'h00, 8'hFF, 8'h01, 8'hFE);
    random_traffic(380, 0, 0);
  endtask

  // Arrow codes that collide with newline and backspace, sender mostly idle.
  task automatic test_sender_gaps();
    write_all_regs(8'hFF, CODE_NEWLINE, CODE_BACKSPACE, 8'd131, 8'd130);
    random_traffic(380, 74, 0);
  endtask

  // Duplicate arrow codes and space as an arrow, receiver mostly stalling.
  task automatic test_receiver_stalls();
    write_all_regs(8'($urandom_range(255)), 8'd200, 8'd200, 8'($urandom_range(255)),
                   CODE_SPACE);
    random_traffic(380, 0, 74);
  endtask

  // Default arrow codes again with idling on both sides.
  task automatic test_both_sides_idle();
    write_all_regs(8'($urandom_range(255)), 8'd128, 8'd129, 8'd130, 8'd131);
    random_traffic(380, 36, 36);
  endtask

  // Receiver back-pressure.
  always @(negedge clk) begin
    m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Compare each result beat with the oldest prediction.
  always @(posedge clk) begin
    cursor_report_t got;
    cursor_report_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got = m_axis_tdata[38:0];
      if (pending_reports.size() == 0) begin
        $error("result beat with nothing expected: %h", m_axis_tdata);
        fail_count++;
      end else begin
        want = pending_reports.pop_front();
        if (got.col !== want.col) begin
          $error("cursor_col mismatch: expected %0d, actual %0d", want.col, got.col);
          fail_count++;
        end
        if (got.row !== want.row) begin
          $error("cursor_row mismatch: expected %0d, actual %0d", want.row, got.row);
          fail_count++;
        end
        if (got.loc !== want.loc) begin
          $error("cursor_loc mismatch: expected %0d, actual %0d", want.loc, got.loc);
          fail_count++;
        end
        if (got.data !== want.data) begin
          $error("cell_data mismatch: expected %h, actual %h", want.data, got.data);
          fail_count++;
        end
      end
    end
  end

  // Watchdog on cycles in which no beat moves on any channel.
  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Watchdog: no beat accepted for %0d cycles, %0d results outstanding",
               quiet_cycles, pending_reports.size());
      $display("*** FAILED ***");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    for (int i = 0; i < CELLS; i++) screen[i] = RESET_CELL;
    pos_col   = 0;
    pos_row   = 0;
    attr      = 8'd15;
    up_key    = 8'd128;
    down_key  = 8'd129;
    left_key  = 8'd130;
    right_key = 8'd131;

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_directed_codes();
    test_scroll_and_edges();
    test_extreme_key_codes();
    test_sender_gaps();
    test_receiver_stalls();
    test_both_sides_idle();

    drain_reports();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (pending_reports.size() != 0) begin
      $error("%0d expected results never arrived", pending_reports.size());
      fail_count++;
    end

    $display("Covered %0d puts and %0d cell reads (%0d beyond the store) with %0d scrolls,",
             put_count, read_count, oob_read_count, scroll_count);
    $display("%0d register writes, and four idling regimes on the two streams.", reg_writes);
    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

[text_console_char_engine.f]
sv/tcce_pkg.sv
sv/tcce_ctrl.sv
sv/tcce_dp.sv
sv/text_console_char_engine.sv
bench/text_console_char_engine_tb.sv
